// ===== hdl/hedtrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hedtrp_pkg
// Shared types, codes and bucket arithmetic for the hierarchical edt policer.
// ----------------------------------------------------------------------------
package hedtrp_pkg;

    // field widths
    localparam int NOW_W   = 62;
    localparam int COST_W  = 30;
    localparam int LIMIT_W = 62;
    localparam int CAP_W   = 63;
    localparam int EDT_W   = 64;

    // the class that also acts as the shared bucket
    localparam int GLOBAL_CLASS = 0;

    // command codes
    localparam logic CMD_PACKET   = 1'b0;
    localparam logic CMD_SETTINGS = 1'b1;

    // verdict codes
    localparam logic [1:0] VERDICT_DROP   = 2'd0;
    localparam logic [1:0] VERDICT_PASS   = 2'd1;
    localparam logic [1:0] VERDICT_STORED = 2'd2;

    // reset values of the per-class settings
    localparam logic [COST_W-1:0] COST_RESET  = COST_W'(1000000000);
    localparam logic [CAP_W-1:0]  LIMIT_RESET = CAP_W'(64'd10000000000);
    localparam logic [CAP_W-1:0]  BURST_RESET = CAP_W'(64'd1000000000);

    typedef logic [EDT_W-1:0] edt_t;

    typedef struct packed {
        edt_t edt;
        edt_t usage;
    } bucket_res_t;

    // signed greater-than on 64-bit patterns
    function automatic logic s_gt(input edt_t a, input edt_t b);
        return $signed(a) > $signed(b);
    endfunction

    // one bucket test: resync when idle, charge unless over cap and not forced
    function automatic bucket_res_t bucket_step(input edt_t edt, input edt_t now,
                                                input edt_t cost, input edt_t cap,
                                                input logic charge_anyway);
        bucket_res_t res;
        edt_t        usage;
        edt_t        charged;
        usage   = edt - now;
        charged = usage + cost;
        if (usage[EDT_W-1])
        begin
            res.edt   = now + cost;
            res.usage = '0;
        end
        else if (!charge_anyway && s_gt(charged, cap))
        begin
            res.edt   = edt;
            res.usage = charged;
        end
        else
        begin
            res.edt   = edt + cost;
            res.usage = usage;
        end
        return res;
    endfunction

endpackage

// ===== hdl/hierarchical_edt_rate_policer_unit.sv =====
// ----------------------------------------------------------------------------
// hierarchical_edt_rate_policer_unit
// Per-class earliest-departure-time policer with borrowing from a shared bucket.
// ----------------------------------------------------------------------------
// Every accepted transaction gives exactly one result transaction. A new
// transaction is taken every cycle unless in_stall is high: it lands in an
// input register, and once the result register is free one pass of logic
// reads the class and shared bucket registers, writes their new values and
// loads the result register, which drives the output. The bucket state sits
// in flip-flops that reset sets directly, so the block is ready straight out
// of reset with no clearing pass. Back-to-back items on the same class see
// each other's updates.
module hierarchical_edt_rate_policer_unit
    import hedtrp_pkg::*;
#(
    parameter int NUM_CLASSES = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [1:0]         class_id,
    input  logic [NOW_W-1:0]   now_ns,
    input  logic [COST_W-1:0]  cost_value,
    input  logic [LIMIT_W-1:0] limit_value,
    input  logic [LIMIT_W-1:0] burst_limit_value,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         verdict,
    output logic [1:0]         class_echo
);

    localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CLS_W = 7;

    // input register
    logic               in_v_reg;
    logic               cmd_reg;
    logic [1:0]         class_reg;
    logic [NOW_W-1:0]   now_reg;
    logic [COST_W-1:0]  cost_in_reg;
    logic [LIMIT_W-1:0] limit_in_reg;
    logic [LIMIT_W-1:0] burst_in_reg;

    // result register
    logic               out_v_reg;
    logic [1:0]         verdict_reg;
    logic [1:0]         class_echo_reg;
    logic [1:0]         verdict_next;

    // bucket state
    edt_t               edt_reg   [NUM_CLASSES];
    logic [COST_W-1:0]  cost_reg  [NUM_CLASSES];
    logic [CAP_W-1:0]   limit_reg [NUM_CLASSES];
    logic [CAP_W-1:0]   burst_reg [NUM_CLASSES];
    edt_t               edt_next  [NUM_CLASSES];

    // handshake
    logic in_accept;
    logic out_free;
    logic move;
    logic in_v_next;
    logic out_v_next;

    // datapath
    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             is_global;
    edt_t             now64;
    edt_t             cost_c;
    edt_t             burst_c;
    edt_t             limit_c;
    edt_t             cost_g;
    edt_t             limit_g;
    edt_t             edt_g_in;
    bucket_res_t      class_res;
    bucket_res_t      glob_res;
    logic             drop_burst;
    logic             within_base;
    logic             refuse;
    logic             glob_touch;
    logic             do_packet;
    logic             do_settings;
    edt_t             base_val;
    edt_t             class_val;

    // pipeline control
    assign out_free  = !out_v_reg || !out_stall;
    assign move      = in_v_reg && out_free;
    assign in_stall  = in_v_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (in_accept)
        begin
            in_v_next = 1'b1;
        end
        else if (move)
        begin
            in_v_next = 1'b0;
        end
    end

    always_comb
    begin
        out_v_next = out_v_reg;
        if (move)
        begin
            out_v_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // capture the input transaction
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= cmd;
            class_reg    <= class_id;
            now_reg      <= now_ns;
            cost_in_reg  <= cost_value;
            limit_in_reg <= limit_value;
            burst_in_reg <= burst_limit_value;
        end
    end

    // class selection
    assign in_range  = CLS_W'(class_reg) < CLS_W'(NUM_CLASSES);
    assign idx       = IDX_W'(class_reg);
    assign is_global = idx == IDX_W'(GLOBAL_CLASS);

    assign now64   = {{(EDT_W-NOW_W){1'b0}}, now_reg};
    assign cost_c  = {{(EDT_W-COST_W){1'b0}}, cost_reg[idx]};
    assign burst_c = {1'b0, burst_reg[idx]};
    assign limit_c = {1'b0, limit_reg[idx]};
    assign cost_g  = {{(EDT_W-COST_W){1'b0}}, cost_reg[GLOBAL_CLASS]};
    assign limit_g = {1'b0, limit_reg[GLOBAL_CLASS]};

    // class bucket against its burst limit
    assign class_res   = bucket_step(edt_reg[idx], now64, cost_c, burst_c, 1'b0);
    assign drop_burst  = s_gt(class_res.usage, burst_c);
    assign within_base = !s_gt(class_res.usage, limit_c);

    // shared bucket sees the class update when it is the same entry
    assign edt_g_in = is_global ? class_res.edt : edt_reg[GLOBAL_CLASS];
    assign glob_res = bucket_step(edt_g_in, now64, cost_g, limit_g, within_base);
    assign refuse   = s_gt(glob_res.usage, limit_g);

    assign do_packet   = move && in_range && (cmd_reg == CMD_PACKET);
    assign do_settings = move && in_range && (cmd_reg == CMD_SETTINGS);
    assign glob_touch  = !drop_burst;

    // final class edt, with refund when borrowing is refused
    assign base_val  = (is_global && glob_touch) ? glob_res.edt : class_res.edt;
    assign class_val = (glob_touch && !within_base && refuse) ? base_val - cost_c
                                                               : base_val;

    always_comb
    begin
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            edt_next[i] = edt_reg[i];
            if (do_packet && (idx == IDX_W'(i)))
            begin
                edt_next[i] = class_val;
            end
            else if (do_packet && glob_touch && (i == GLOBAL_CLASS))
            begin
                edt_next[i] = glob_res.edt;
            end
        end
    end

    // bucket and settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                edt_reg[i]   <= '0;
                cost_reg[i]  <= COST_RESET;
                limit_reg[i] <= LIMIT_RESET;
                burst_reg[i] <= BURST_RESET;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                edt_reg[i] <= edt_next[i];
                if (do_settings && (idx == IDX_W'(i)))
                begin
                    cost_reg[i]  <= cost_in_reg;
                    limit_reg[i] <= {1'b0, limit_in_reg};
                    burst_reg[i] <= {1'b0, burst_in_reg};
                end
            end
        end
    end

    // verdict
    always_comb
    begin
        verdict_next = VERDICT_DROP;
        if (in_range)
        begin
            if (cmd_reg == CMD_SETTINGS)
            begin
                verdict_next = VERDICT_STORED;
            end
            else if (!drop_burst && (within_base || !refuse))
            begin
                verdict_next = VERDICT_PASS;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            verdict_reg    <= verdict_next;
            class_echo_reg <= class_reg;
        end
    end

    assign out_valid  = out_v_reg;
    assign verdict    = verdict_reg;
    assign class_echo = class_echo_reg;

endmodule

// ===== hdl/hedtrp_checker.sv =====
// ----------------------------------------------------------------------------
// hedtrp_checker
// Port-level checks for the hierarchical edt policer, bound to the top level.
// ----------------------------------------------------------------------------
module hedtrp_checker
    import hedtrp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] verdict,
    input logic [1:0] class_echo
);

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(class_echo))
        else $error("stalled result changed");

    // input side backs up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

    // an accepted transaction moves on to the output once the output has emptied
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_valid |=> out_valid)
        else $error("accepted transaction did not reach the output");

    // only defined verdict codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == VERDICT_DROP) || (verdict == VERDICT_PASS)
                      || (verdict == VERDICT_STORED))
        else $error("undefined verdict code");

endmodule

bind hierarchical_edt_rate_policer_unit hedtrp_checker u_hedtrp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .verdict    (verdict),
    .class_echo (class_echo)
);
